/* src/rgb_to_spectrum_smits_macros.svh */
// ----------------------------------------------------------------------------
// RGB to spectrum assertion macros
// Shared concurrent assertion forms, clocked on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_SPECTRUM_SMITS_MACROS_SVH
`define RGB_TO_SPECTRUM_SMITS_MACROS_SVH

// Same-cycle implication
`define RTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rts: same-cycle check failed");

// Next-cycle implication
`define RTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rts: next-cycle check failed");

`endif

/* src/rts_pkg.sv */
// ----------------------------------------------------------------------------
// rts_pkg
// Types, constants and address helpers for the RGB to spectrum converter.
// ----------------------------------------------------------------------------
package rts_pkg;

    localparam int NUM_SAMPLES = 64;

    localparam int IDX_W   = 6;
    localparam int CHAN_W  = 16;
    localparam int BASIS_W = 16;
    localparam int VALUE_W = 24;

    localparam int NUM_COLOR_BASES = 3;
    localparam int WHITE_DEPTH = 2 * NUM_SAMPLES;
    localparam int COLOR_DEPTH = 2 * NUM_COLOR_BASES * NUM_SAMPLES;
    localparam int WHITE_AW = (WHITE_DEPTH > 1) ? $clog2(WHITE_DEPTH) : 1;
    localparam int COLOR_AW = $clog2(COLOR_DEPTH);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SAMPLES - 1);

    // Item modes
    localparam logic MODE_CONVERT = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    // Basis codes as carried by basis_select
    localparam logic [2:0] BASIS_WHITE   = 3'd0;
    localparam logic [2:0] BASIS_CYAN    = 3'd1;
    localparam logic [2:0] BASIS_MAGENTA = 3'd2;
    localparam logic [2:0] BASIS_YELLOW  = 3'd3;
    localparam logic [2:0] BASIS_RED     = 3'd4;
    localparam logic [2:0] BASIS_GREEN   = 3'd5;
    localparam logic [2:0] BASIS_BLUE    = 3'd6;

    // Local codes inside the secondary and primary stores
    localparam logic [1:0] SEC_CYAN    = 2'd0;
    localparam logic [1:0] SEC_MAGENTA = 2'd1;
    localparam logic [1:0] SEC_YELLOW  = 2'd2;
    localparam logic [1:0] PRI_RED     = 2'd0;
    localparam logic [1:0] PRI_GREEN   = 2'd1;
    localparam logic [1:0] PRI_BLUE    = 2'd2;

    // Datapath widths
    localparam int PROD_W  = CHAN_W + 1 + BASIS_W;  // unsigned weight x signed basis
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT   = 10;
    localparam int ROUND_W = SUM_W - SHIFT;

    typedef struct packed {
        logic                      mode;
        logic                      spectrum_kind;
        logic [CHAN_W-1:0]         red_in;
        logic [CHAN_W-1:0]         green_in;
        logic [CHAN_W-1:0]         blue_in;
        logic [2:0]                basis_select;
        logic [IDX_W-1:0]          load_index;
        logic signed [BASIS_W-1:0] load_value;
    } rts_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]          sample_index;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      last_sample;
    } rts_result_t;

    // Tag that travels with each sample through the pipeline
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] sample_index;
        logic             last_sample;
    } rts_tag_t;

    typedef struct packed {
        logic [CHAN_W-1:0]         w_white;
        logic [CHAN_W-1:0]         w_sec;
        logic [CHAN_W-1:0]         w_pri;
        logic signed [BASIS_W-1:0] b_white;
        logic signed [BASIS_W-1:0] b_sec;
        logic signed [BASIS_W-1:0] b_pri;
    } rts_operands_t;

    function automatic logic [WHITE_AW-1:0] white_addr(input logic kind,
                                                       input logic [IDX_W-1:0] idx);
        int a;
        a = int'(kind) * NUM_SAMPLES + int'(idx);
        return WHITE_AW'(a);
    endfunction

    function automatic logic [COLOR_AW-1:0] color_addr(input logic kind,
                                                       input logic [1:0] sel,
                                                       input logic [IDX_W-1:0] idx);
        int a;
        a = (int'(kind) * NUM_COLOR_BASES + int'(sel)) * NUM_SAMPLES + int'(idx);
        return COLOR_AW'(a);
    endfunction

endpackage

/* src/rts_datapath.sv */
// ----------------------------------------------------------------------------
// rts_datapath
// Multiply, sum with rounding, and saturate, ending in the output register.
// ----------------------------------------------------------------------------
module rts_datapath
    import rts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rts_tag_t      tag,
    input  rts_operands_t ops,
    output logic          advance,
    output logic          result_valid,
    input  logic          result_ready,
    output rts_result_t   result
);

    rts_tag_t                 tag_mul_reg;
    logic signed [PROD_W-1:0] p_white_reg, p_sec_reg, p_pri_reg;
    logic signed [PROD_W-1:0] p_white_next, p_sec_next, p_pri_next;

    rts_tag_t                  tag_sum_reg;
    logic signed [ROUND_W-1:0] rnd_reg;
    logic signed [ROUND_W-1:0] rnd_next;
    logic signed [SUM_W-1:0]   sum;

    rts_result_t out_reg;
    rts_result_t out_next;
    logic        out_valid_reg;

    localparam logic signed [ROUND_W-1:0] SAT_MAX = ROUND_W'((1 << (VALUE_W - 1)) - 1);
    localparam logic signed [ROUND_W-1:0] SAT_MIN = -ROUND_W'(1 << (VALUE_W - 1));

    assign advance = !out_valid_reg || result_ready;

    always_comb
    begin
        p_white_next = PROD_W'($signed({1'b0, ops.w_white})) * PROD_W'(ops.b_white);
        p_sec_next   = PROD_W'($signed({1'b0, ops.w_sec})) * PROD_W'(ops.b_sec);
        p_pri_next   = PROD_W'($signed({1'b0, ops.w_pri})) * PROD_W'(ops.b_pri);
    end

    // round half up to 16 fraction bits: floor((sum + 2^9) / 2^10)
    always_comb
    begin
        sum      = SUM_W'(p_white_reg) + SUM_W'(p_sec_reg) + SUM_W'(p_pri_reg)
                 + SUM_W'(1 << (SHIFT - 1));
        rnd_next = ROUND_W'(sum >>> SHIFT);
    end

    always_comb
    begin
        out_next.sample_index = tag_sum_reg.sample_index;
        out_next.last_sample  = tag_sum_reg.last_sample;
        if (rnd_reg > SAT_MAX)
            out_next.sample_value = VALUE_W'(SAT_MAX);
        else if (rnd_reg < SAT_MIN)
            out_next.sample_value = VALUE_W'(SAT_MIN);
        else
            out_next.sample_value = VALUE_W'(rnd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_mul_reg   <= '0;
            tag_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tag_mul_reg   <= tag;
            tag_sum_reg   <= tag_mul_reg;
            out_valid_reg <= tag_sum_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_white_reg <= p_white_next;
            p_sec_reg   <= p_sec_next;
            p_pri_reg   <= p_pri_next;
            rnd_reg     <= rnd_next;
            out_reg     <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* src/rgb_to_spectrum_smits.sv */
// ----------------------------------------------------------------------------
// rgb_to_spectrum_smits
// RGB to sampled spectrum by the Smits basis method, with loadable bases.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  item     | item_valid / item_ready     | item   (rts_item_t)
//  result   | result_valid / result_ready | result (rts_result_t)
//
// A load transaction is written to the basis store in the cycle it is taken.
// A convert transaction occupies the sample sequencer until it has issued all
// NUM_SAMPLES samples (one store read per sample); no new item is taken until
// the last sample has been issued.
// Stages: store read, multiply, sum/round, saturate/output; all share one stall.
// Reset clears control only; basis store contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "rgb_to_spectrum_smits_macros.svh"

module rgb_to_spectrum_smits
    import rts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  rts_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output rts_result_t result
);

    logic signed [BASIS_W-1:0] white_mem [WHITE_DEPTH];
    logic signed [BASIS_W-1:0] sec_mem   [COLOR_DEPTH];
    logic signed [BASIS_W-1:0] pri_mem   [COLOR_DEPTH];

    logic busy_reg;
    logic [IDX_W-1:0] count_reg;
    logic kind_reg;
    logic [1:0] sec_sel_reg, pri_sel_reg;
    logic [CHAN_W-1:0] w_white_reg, w_sec_reg, w_pri_reg;

    logic [1:0] sec_sel_next, pri_sel_next;
    logic [CHAN_W-1:0] w_white_next, w_sec_next, w_pri_next;

    logic accept, accept_convert, accept_load;
    logic wr_white, wr_sec, wr_pri;
    logic [1:0] wr_sel;
    logic advance, issue;

    rts_tag_t                  tag_rd_reg;
    logic signed [BASIS_W-1:0] b_white_rd_reg, b_sec_rd_reg, b_pri_rd_reg;
    logic [CHAN_W-1:0]         w_white_rd_reg, w_sec_rd_reg, w_pri_rd_reg;
    rts_operands_t             ops_rd;

    assign item_ready     = !busy_reg;
    assign accept         = item_valid && item_ready;
    assign accept_convert = accept && (item.mode == MODE_CONVERT);
    assign accept_load    = accept && (item.mode == MODE_LOAD);
    assign issue          = busy_reg && advance;

    // Smits selection: fixed branch order, ties go to the earlier branch
    always_comb
    begin
        if (item.red_in <= item.blue_in && item.red_in <= item.green_in)
        begin
            w_white_next = item.red_in;
            sec_sel_next = SEC_CYAN;
            if (item.green_in <= item.blue_in)
            begin
                w_sec_next   = item.green_in - item.red_in;
                pri_sel_next = PRI_BLUE;
                w_pri_next   = item.blue_in - item.green_in;
            end
            else
            begin
                w_sec_next   = item.blue_in - item.red_in;
                pri_sel_next = PRI_GREEN;
                w_pri_next   = item.green_in - item.blue_in;
            end
        end
        else if (item.green_in <= item.red_in && item.green_in <= item.blue_in)
        begin
            w_white_next = item.green_in;
            sec_sel_next = SEC_MAGENTA;
            if (item.red_in <= item.blue_in)
            begin
                w_sec_next   = item.red_in - item.green_in;
                pri_sel_next = PRI_BLUE;
                w_pri_next   = item.blue_in - item.red_in;
            end
            else
            begin
                w_sec_next   = item.blue_in - item.green_in;
                pri_sel_next = PRI_RED;
                w_pri_next   = item.red_in - item.blue_in;
            end
        end
        else
        begin
            w_white_next = item.blue_in;
            sec_sel_next = SEC_YELLOW;
            if (item.red_in <= item.green_in)
            begin
                w_sec_next   = item.red_in - item.blue_in;
                pri_sel_next = PRI_GREEN;
                w_pri_next   = item.green_in - item.red_in;
            end
            else
            begin
                w_sec_next   = item.green_in - item.blue_in;
                pri_sel_next = PRI_RED;
                w_pri_next   = item.red_in - item.green_in;
            end
        end
    end

    // Load routing; bad basis codes and out-of-range indexes write nothing
    always_comb
    begin
        wr_white = 1'b0;
        wr_sec   = 1'b0;
        wr_pri   = 1'b0;
        wr_sel   = 2'd0;
        if (accept_load && int'(item.load_index) < NUM_SAMPLES)
        begin
            unique case (item.basis_select) inside
                BASIS_WHITE:
                    wr_white = 1'b1;
                BASIS_CYAN, BASIS_MAGENTA, BASIS_YELLOW:
                begin
                    wr_sec = 1'b1;
                    wr_sel = 2'(item.basis_select - BASIS_CYAN);
                end
                BASIS_RED, BASIS_GREEN, BASIS_BLUE:
                begin
                    wr_pri = 1'b1;
                    wr_sel = 2'(item.basis_select - BASIS_RED);
                end
                default:
                    wr_white = 1'b0;
            endcase
        end
    end

    // Sample sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (accept_convert)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (issue)
        begin
            if (count_reg == LAST_IDX)
                busy_reg <= 1'b0;
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_convert)
        begin
            kind_reg    <= item.spectrum_kind;
            sec_sel_reg <= sec_sel_next;
            pri_sel_reg <= pri_sel_next;
            w_white_reg <= w_white_next;
            w_sec_reg   <= w_sec_next;
            w_pri_reg   <= w_pri_next;
        end
    end

    // Basis stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (wr_white)
            white_mem[white_addr(item.spectrum_kind, item.load_index)] <= item.load_value;
        if (issue)
            b_white_rd_reg <= white_mem[white_addr(kind_reg, count_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (wr_sec)
            sec_mem[color_addr(item.spectrum_kind, wr_sel, item.load_index)]
                <= item.load_value;
        if (issue)
            b_sec_rd_reg <= sec_mem[color_addr(kind_reg, sec_sel_reg, count_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (wr_pri)
            pri_mem[color_addr(item.spectrum_kind, wr_sel, item.load_index)]
                <= item.load_value;
        if (issue)
            b_pri_rd_reg <= pri_mem[color_addr(kind_reg, pri_sel_reg, count_reg)];
    end

    // Read stage tag and weights
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_rd_reg <= '0;
        else if (advance)
        begin
            tag_rd_reg.valid <= busy_reg;
            if (busy_reg)
            begin
                tag_rd_reg.sample_index <= count_reg;
                tag_rd_reg.last_sample  <= (count_reg == LAST_IDX);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            w_white_rd_reg <= w_white_reg;
            w_sec_rd_reg   <= w_sec_reg;
            w_pri_rd_reg   <= w_pri_reg;
        end
    end

    always_comb
    begin
        ops_rd.w_white = w_white_rd_reg;
        ops_rd.w_sec   = w_sec_rd_reg;
        ops_rd.w_pri   = w_pri_rd_reg;
        ops_rd.b_white = b_white_rd_reg;
        ops_rd.b_sec   = b_sec_rd_reg;
        ops_rd.b_pri   = b_pri_rd_reg;
    end

    rts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag          (tag_rd_reg),
        .ops          (ops_rd),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `RTS_ASSERT_NEXT(a_convert_starts, accept_convert, busy_reg && count_reg == '0)
    `RTS_ASSERT_NEXT(a_last_issue_ends, issue && count_reg == LAST_IDX, !busy_reg)
    `RTS_ASSERT_SAME(a_last_flag_pos, result_valid && result.last_sample,
                     result.sample_index == LAST_IDX)

endmodule
